FILE: rtl/rwip_pkg.sv
package rwip_pkg;

  localparam int WORD_BITS = 64;
  localparam int VAL_BITS  = 2 * WORD_BITS;
  localparam int LZ_BITS   = $clog2(VAL_BITS);
  localparam int PREC_BITS = 8;
  localparam int MODE_BITS = 3;
  localparam int EXP_BITS  = 8;
  localparam int CNT_BITS  = 2;
  localparam int IDX_BITS  = 8;
  localparam int CFG_BITS  = 8;

  localparam logic [PREC_BITS-1:0] PREC_RESET = PREC_BITS'(64);

  localparam logic [MODE_BITS-1:0] MODE_TO_ZERO   = 3'd0;
  localparam logic [MODE_BITS-1:0] MODE_AWAY      = 3'd1;
  localparam logic [MODE_BITS-1:0] MODE_FLOOR     = 3'd2;
  localparam logic [MODE_BITS-1:0] MODE_CEIL      = 3'd3;
  localparam logic [MODE_BITS-1:0] MODE_NEAR_EVEN = 3'd4;

  localparam logic [IDX_BITS-1:0] REG_PRECISION = 8'd0;
  localparam logic [IDX_BITS-1:0] REG_MODE      = 8'd1;

  localparam logic [CNT_BITS-1:0] ONE_WORD  = 2'd1;
  localparam logic [CNT_BITS-1:0] TWO_WORDS = 2'd2;

  typedef struct packed {
    logic [VAL_BITS-1:0] value;
    logic [LZ_BITS-1:0]  lead;
    logic                zero;
    logic                neg;
  } lzc_beat_t;

  typedef struct packed {
    logic [VAL_BITS-1:0] norm;
    logic [LZ_BITS-1:0]  lead;
    logic                zero;
    logic                neg;
  } norm_beat_t;

  typedef struct packed {
    logic [VAL_BITS-1:0] kept;
    logic [LZ_BITS-1:0]  d;
    logic                up;
    logic                inexact;
    logic [LZ_BITS-1:0]  lead;
    logic                zero;
    logic                neg;
  } rnd_beat_t;

  typedef struct packed {
    logic                       zero_input;
    logic                       negative_out;
    logic                       inexact;
    logic signed [EXP_BITS-1:0] exponent_adjust;
    logic [CNT_BITS-1:0]        word_count;
    logic [WORD_BITS-1:0]       mantissa_bottom;
    logic [WORD_BITS-1:0]       mantissa_top;
  } res_beat_t;

  typedef struct packed {
    logic [PREC_BITS-1:0] precision_bits;
    logic [MODE_BITS-1:0] rounding_mode;
  } cfg_t;

endpackage

FILE: rtl/rwip_lzc.sv
module rwip_lzc (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [rwip_pkg::WORD_BITS-1:0]  high_word,
  input  logic [rwip_pkg::WORD_BITS-1:0]  low_word,
  input  logic                            negative,
  output logic                            out_valid,
  input  logic                            out_ready,
  output rwip_pkg::lzc_beat_t             out_beat
);

  logic                          valid_r;
  rwip_pkg::lzc_beat_t           beat_r;
  rwip_pkg::lzc_beat_t           beat_nxt;
  logic [rwip_pkg::VAL_BITS-1:0] value;

  assign value    = {high_word, low_word};
  assign in_ready = !valid_r || out_ready;

  // priority encode: highest set bit wins, last assignment in the loop
  always_comb begin
    beat_nxt       = '0;
    beat_nxt.value = value;
    beat_nxt.neg   = negative;
    beat_nxt.zero  = (value == '0);
    for (int i = 0; i < rwip_pkg::VAL_BITS; i++) begin
      if (value[i]) begin
        beat_nxt.lead = rwip_pkg::LZ_BITS'(rwip_pkg::VAL_BITS - 1 - i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      beat_r <= beat_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_beat  = beat_r;

endmodule

FILE: rtl/rwip_norm.sv
module rwip_norm (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rwip_pkg::lzc_beat_t  in_beat,
  output logic                 out_valid,
  input  logic                 out_ready,
  output rwip_pkg::norm_beat_t out_beat
);

  logic                 valid_r;
  rwip_pkg::norm_beat_t beat_r;
  rwip_pkg::norm_beat_t beat_nxt;

  assign in_ready = !valid_r || out_ready;

  always_comb begin
    beat_nxt.norm = in_beat.value << in_beat.lead;
    beat_nxt.lead = in_beat.lead;
    beat_nxt.zero = in_beat.zero;
    beat_nxt.neg  = in_beat.neg;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      beat_r <= beat_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_beat  = beat_r;

endmodule

FILE: rtl/rwip_round.sv
module rwip_round (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rwip_pkg::cfg_t       cfg,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rwip_pkg::norm_beat_t in_beat,
  output logic                 out_valid,
  input  logic                 out_ready,
  output rwip_pkg::rnd_beat_t  out_beat
);

  logic                           valid_r;
  rwip_pkg::rnd_beat_t            beat_r;
  rwip_pkg::rnd_beat_t            beat_nxt;
  logic [rwip_pkg::PREC_BITS-1:0] prec;
  logic [rwip_pkg::PREC_BITS:0]   d_full;
  logic [rwip_pkg::LZ_BITS-1:0]   d;
  logic [rwip_pkg::VAL_BITS-1:0]  mask;
  logic                           inexact;
  logic                           rb;
  logic                           sticky;
  logic                           lsb;
  logic                           up;

  assign in_ready = !valid_r || out_ready;

  always_comb begin
    prec = cfg.precision_bits;
    if (prec == '0) begin
      prec = rwip_pkg::PREC_BITS'(1);
    end else if (prec > rwip_pkg::PREC_BITS'(rwip_pkg::VAL_BITS)) begin
      prec = rwip_pkg::PREC_BITS'(rwip_pkg::VAL_BITS);
    end
    d_full  = (rwip_pkg::PREC_BITS+1)'(rwip_pkg::VAL_BITS) - {1'b0, prec};
    d       = d_full[rwip_pkg::LZ_BITS-1:0];
    mask    = ~({rwip_pkg::VAL_BITS{1'b1}} << d);
    inexact = |(in_beat.norm & mask);
    rb      = (d != '0) && in_beat.norm[d - rwip_pkg::LZ_BITS'(1)];
    sticky  = |(in_beat.norm & (mask >> 1));
    lsb     = in_beat.norm[d];
    up      = 1'b0;
    if (inexact) begin
      case (cfg.rounding_mode)
        rwip_pkg::MODE_AWAY:      up = 1'b1;
        rwip_pkg::MODE_FLOOR:     up = in_beat.neg;
        rwip_pkg::MODE_CEIL:      up = !in_beat.neg;
        rwip_pkg::MODE_NEAR_EVEN: up = rb && (sticky || lsb);
        default:                  up = 1'b0;
      endcase
    end
    beat_nxt.kept    = in_beat.norm & ~mask;
    beat_nxt.d       = d;
    beat_nxt.up      = up;
    beat_nxt.inexact = inexact;
    beat_nxt.lead    = in_beat.lead;
    beat_nxt.zero    = in_beat.zero;
    beat_nxt.neg     = in_beat.neg;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      beat_r <= beat_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_beat  = beat_r;

endmodule

FILE: rtl/rwip_incr.sv
module rwip_incr (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  rwip_pkg::rnd_beat_t in_beat,
  output logic                out_valid,
  input  logic                out_ready,
  output rwip_pkg::res_beat_t out_beat
);

  logic                          valid_r;
  rwip_pkg::res_beat_t           beat_r;
  rwip_pkg::res_beat_t           beat_nxt;
  logic [rwip_pkg::VAL_BITS:0]   step;
  logic [rwip_pkg::VAL_BITS:0]   sum;
  logic [rwip_pkg::VAL_BITS-1:0] mant;
  logic                          carry;
  logic [rwip_pkg::EXP_BITS-1:0] neg_lead;

  assign in_ready = !valid_r || out_ready;

  always_comb begin
    step     = {{rwip_pkg::VAL_BITS{1'b0}}, 1'b1} << in_beat.d;
    sum      = {1'b0, in_beat.kept} + (in_beat.up ? step : '0);
    carry    = sum[rwip_pkg::VAL_BITS];
    mant     = carry ? {1'b1, {(rwip_pkg::VAL_BITS-1){1'b0}}}
                     : sum[rwip_pkg::VAL_BITS-1:0];
    neg_lead = rwip_pkg::EXP_BITS'(0) - rwip_pkg::EXP_BITS'(in_beat.lead);

    beat_nxt.negative_out = in_beat.neg;
    if (in_beat.zero) begin
      beat_nxt.zero_input      = 1'b1;
      beat_nxt.mantissa_top    = '0;
      beat_nxt.mantissa_bottom = '0;
      beat_nxt.word_count      = rwip_pkg::ONE_WORD;
      beat_nxt.exponent_adjust = '0;
      beat_nxt.inexact         = 1'b0;
    end else begin
      beat_nxt.zero_input      = 1'b0;
      beat_nxt.mantissa_top    = mant[rwip_pkg::VAL_BITS-1:rwip_pkg::WORD_BITS];
      beat_nxt.mantissa_bottom = mant[rwip_pkg::WORD_BITS-1:0];
      beat_nxt.word_count      = (mant[rwip_pkg::WORD_BITS-1:0] != '0) ?
                                 rwip_pkg::TWO_WORDS : rwip_pkg::ONE_WORD;
      beat_nxt.exponent_adjust = neg_lead + rwip_pkg::EXP_BITS'(carry);
      beat_nxt.inexact         = in_beat.inexact;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      beat_r <= beat_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_beat  = beat_r;

endmodule

FILE: rtl/round_wide_integer_to_precision.sv
// Rounds a 128-bit magnitude (two 64-bit words plus sign) to
// precision_bits significant bits, top-aligned, under one of five modes.
// Input beat (in_*): one value per beat. Result beat (out_*): one result
// per input, in order. Config (cfg_*): index 0 precision_bits, 1
// rounding_mode; cfg_ready is always high, write only while idle.
// Pipeline: leading-zero count, normalize shift, round decision,
// increment. Each stage is a register with its own valid bit.
// Throughput: one beat per cycle while out_tready stays high.
// A stage takes a new beat when empty or when its content moves on, so a
// stalled out_tready backs up the pipe; up to four beats stay in flight
// and nothing is dropped or repeated.
// Reset clears all valid bits and loads precision_bits = 64,
// rounding_mode = nearest-even.
// Zero input gives zero_input = 1 and a zero mantissa.
module round_wide_integer_to_precision (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [63:0] high_word, [127:64] low_word, [128] negative, rest zero
  input  logic [135:0]                    in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [63:0] mantissa_top, [127:64] mantissa_bottom, [129:128] word_count,
  // [137:130] exponent_adjust, [138] inexact, [139] negative_out,
  // [140] zero_input, rest zero
  output logic [143:0]                    out_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rwip_pkg::IDX_BITS-1:0]   cfg_index,
  input  logic [rwip_pkg::CFG_BITS-1:0]   cfg_data
);

  rwip_pkg::cfg_t       cfg_r;
  logic                 s1_valid, s1_ready;
  logic                 s2_valid, s2_ready;
  logic                 s3_valid, s3_ready;
  rwip_pkg::lzc_beat_t  s1_beat;
  rwip_pkg::norm_beat_t s2_beat;
  rwip_pkg::rnd_beat_t  s3_beat;
  rwip_pkg::res_beat_t  res_beat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.precision_bits <= rwip_pkg::PREC_RESET;
      cfg_r.rounding_mode  <= rwip_pkg::MODE_NEAR_EVEN;
    end else if (cfg_valid) begin
      case (cfg_index)
        rwip_pkg::REG_PRECISION: cfg_r.precision_bits <= cfg_data;
        rwip_pkg::REG_MODE:
          cfg_r.rounding_mode <= cfg_data[rwip_pkg::MODE_BITS-1:0];
        default: ;
      endcase
    end
  end

  rwip_lzc u_lzc (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .high_word (in_tdata[63:0]),
    .low_word  (in_tdata[127:64]),
    .negative  (in_tdata[128]),
    .out_valid (s1_valid),
    .out_ready (s1_ready),
    .out_beat  (s1_beat)
  );

  rwip_norm u_norm (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s1_valid),
    .in_ready  (s1_ready),
    .in_beat   (s1_beat),
    .out_valid (s2_valid),
    .out_ready (s2_ready),
    .out_beat  (s2_beat)
  );

  rwip_round u_round (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (s2_valid),
    .in_ready  (s2_ready),
    .in_beat   (s2_beat),
    .out_valid (s3_valid),
    .out_ready (s3_ready),
    .out_beat  (s3_beat)
  );

  rwip_incr u_incr (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s3_valid),
    .in_ready  (s3_ready),
    .in_beat   (s3_beat),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_beat  (res_beat)
  );

  assign out_tdata = {3'b000, res_beat};

endmodule

FILE: verif/tb_top.sv
module tb_top;
  import rwip_pkg::*;

  typedef struct packed {
    logic [WORD_BITS-1:0] hi;
    logic [WORD_BITS-1:0] lo;
    logic                 sign;
  } value_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [135:0]        in_tdata = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [143:0]        out_tdata;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_BITS-1:0] cfg_data = '0;

  round_wide_integer_to_precision dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  value_t    pending_values[$];
  res_beat_t pending_results[$];

  logic [PREC_BITS-1:0] model_prec = PREC_RESET;
  logic [MODE_BITS-1:0] model_mode = MODE_NEAR_EVEN;

  int unsigned errors = 0;
  int unsigned n_values = 0;
  int unsigned n_inexact = 0;
  int unsigned n_zero = 0;
  int unsigned n_two_words = 0;
  int unsigned n_settings = 1;
  int unsigned send_idle_max = 9;
  int unsigned take_idle_max = 9;

  // sender state
  int unsigned send_gap = 0;
  bit          send_busy = 0;
  bit          send_done = 0;
  // receiver state
  int unsigned take_wait = 0;
  bit          take_done = 0;

  function automatic res_beat_t round_to_precision(input logic [WORD_BITS-1:0] hi,
                                                   input logic [WORD_BITS-1:0] lo,
                                                   input logic sign,
                                                   input logic [PREC_BITS-1:0] prec,
                                                   input logic [MODE_BITS-1:0] mode);
    res_beat_t           r;
    logic [VAL_BITS-1:0] norm;
    logic [VAL_BITS-1:0] drop_mask;
    logic [VAL_BITS-1:0] kept;
    logic [VAL_BITS:0]   sum;
    int unsigned         lead;
    int unsigned         keep;
    int unsigned         d;
    logic                lost;
    logic                up;
    logic                carry;
    r = '0;
    r.negative_out = sign;
    norm = {hi, lo};
    if (norm == '0) begin
      r.zero_input = 1'b1;
      r.word_count = ONE_WORD;
      return r;
    end
    lead = 0;
    while (!norm[VAL_BITS-1]) begin
      norm = norm << 1;
      lead++;
    end
    keep = (prec == 0) ? 1 : ((prec > VAL_BITS) ? VAL_BITS : int'(prec));
    d = VAL_BITS - keep;
    drop_mask = (VAL_BITS'(1) << d) - VAL_BITS'(1);
    kept = norm & ~drop_mask;
    lost = |(norm & drop_mask);
    up = 1'b0;
    if (lost) begin
      case (mode)
        MODE_AWAY:      up = 1'b1;
        MODE_FLOOR:     up = sign;
        MODE_CEIL:      up = !sign;
        MODE_NEAR_EVEN: up = norm[d-1] && ((|(norm & (drop_mask >> 1))) || norm[d]);
        default:        up = 1'b0;
      endcase
    end
    carry = 1'b0;
    if (up) begin
      sum = {1'b0, kept} + ((VAL_BITS + 1)'(1) << d);
      carry = sum[VAL_BITS];
      kept = carry ? {1'b1, {(VAL_BITS-1){1'b0}}} : sum[VAL_BITS-1:0];
    end
    r.mantissa_top = kept[VAL_BITS-1:WORD_BITS];
    r.mantissa_bottom = kept[WORD_BITS-1:0];
    r.word_count = (kept[WORD_BITS-1:0] != '0) ? TWO_WORDS : ONE_WORD;
    r.exponent_adjust = EXP_BITS'(int'(carry) - int'(lead));
    r.inexact = lost;
    return r;
  endfunction

  // biased toward ties, exact cuts and carries at the current precision
  function automatic value_t pick_value(input logic [PREC_BITS-1:0] prec);
    value_t              v;
    logic [VAL_BITS-1:0] m;
    logic [VAL_BITS-1:0] drop_mask;
    int unsigned         d;
    int unsigned         kind;
    int unsigned         sh;
    d = (prec == 0) ? VAL_BITS - 1 : ((prec >= VAL_BITS) ? 0 : VAL_BITS - int'(prec));
    drop_mask = (VAL_BITS'(1) << d) - VAL_BITS'(1);
    m = {$urandom, $urandom, $urandom, $urandom};
    m[VAL_BITS-1] = 1'b1;
    kind = $urandom_range(0, 9);
    case (kind)
      3: if (d > 0) begin
        m = m & ~drop_mask;
        m[d-1] = 1'b1;
      end
      4: m = m & ~drop_mask;
      5: m = m | ~drop_mask;
      6: if (d > 0) begin
        m = (m | ~drop_mask) & ~drop_mask;
        m[d-1] = 1'b1;
      end
      7: m = VAL_BITS'(1) << $urandom_range(0, VAL_BITS - 1);
      8: m = (VAL_BITS'(1) << $urandom_range(0, VAL_BITS - 1)) |
             (VAL_BITS'(1) << $urandom_range(0, VAL_BITS - 1));
      default: ;
    endcase
    if (kind < 7) begin
      sh = $urandom_range(0, 1) ? $urandom_range(0, 7) : $urandom_range(0, VAL_BITS - 1);
      m = m >> sh;
    end
    if ($urandom_range(0, 59) == 0)
      m = '0;
    v.hi = m[VAL_BITS-1:WORD_BITS];
    v.lo = m[WORD_BITS-1:0];
    v.sign = 1'($urandom_range(0, 1));
    return v;
  endfunction

  task automatic flag_error(input string what, input res_beat_t want, input res_beat_t got);
    errors++;
    if (errors <= 10) begin
      $display("%s", what);
      $display("  want top=%h bot=%h wc=%0d exp=%0d inx=%b neg=%b zero=%b",
               want.mantissa_top, want.mantissa_bottom, want.word_count,
               want.exponent_adjust, want.inexact, want.negative_out, want.zero_input);
      $display("  got  top=%h bot=%h wc=%0d exp=%0d inx=%b neg=%b zero=%b",
               got.mantissa_top, got.mantissa_bottom, got.word_count,
               got.exponent_adjust, got.inexact, got.negative_out, got.zero_input);
    end
  endtask

  task automatic write_reg(input logic [IDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_PRECISION)
      model_prec = val;
    else if (idx == REG_MODE)
      model_mode = val[MODE_BITS-1:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_rounding(input logic [PREC_BITS-1:0] prec, input logic [CFG_BITS-1:0] mode);
    write_reg(REG_PRECISION, prec);
    write_reg(REG_MODE, mode);
    n_settings++;
  endtask

  task automatic drain();
    while (pending_values.size() != 0 || send_busy || pending_results.size() != 0)
      @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic queue_random(input int unsigned n);
    repeat (n) pending_values.push_back(pick_value(model_prec));
  endtask

  task automatic queue_directed();
    pending_values.push_back('{hi: '1, lo: '1, sign: 1'b1});
    pending_values.push_back('{hi: '0, lo: 64'd1, sign: 1'b0});
    pending_values.push_back('{hi: '0, lo: '0, sign: 1'b1});
    pending_values.push_back('{hi: 64'h8000_0000_0000_0000, lo: 64'h8000_0000_0000_0000,
                               sign: 1'b0});
    pending_values.push_back('{hi: 64'h8000_0000_0000_0001, lo: 64'h8000_0000_0000_0000,
                               sign: 1'b1});
  endtask

  // sender: one beat per item, random gap before the next
  always @(negedge clk) begin
    if (rst_n) begin
      if (send_done) begin
        send_busy = 0;
        send_done = 0;
      end
      if (!send_busy) begin
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (pending_values.size() != 0) begin
          value_t v;
          v = pending_values.pop_front();
          in_tdata <= {7'b0, v.sign, v.lo, v.hi};
          in_tvalid <= 1'b1;
          send_busy = 1;
          send_gap = $urandom_range(0, send_idle_max);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stall after each result beat
  always @(negedge clk) begin
    if (rst_n) begin
      if (take_done) begin
        take_wait = $urandom_range(0, take_idle_max);
        take_done = 0;
      end
      if (take_wait > 0) begin
        take_wait--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        res_beat_t want;
        want = round_to_precision(in_tdata[63:0], in_tdata[127:64], in_tdata[128],
                                  model_prec, model_mode);
        pending_results.push_back(want);
        n_values++;
        n_inexact += want.inexact;
        n_zero += want.zero_input;
        n_two_words += (want.word_count == TWO_WORDS);
        send_done = 1;
      end
      if (out_tvalid && out_tready) begin
        res_beat_t got;
        res_beat_t want;
        got = res_beat_t'(out_tdata[$bits(res_beat_t)-1:0]);
        if (pending_results.size() == 0) begin
          flag_error("result beat with nothing pending", '0, got);
        end else begin
          want = pending_results.pop_front();
          if (got.mantissa_top !== want.mantissa_top ||
              got.mantissa_bottom !== want.mantissa_bottom ||
              got.word_count !== want.word_count ||
              got.exponent_adjust !== want.exponent_adjust ||
              got.inexact !== want.inexact ||
              got.negative_out !== want.negative_out ||
              got.zero_input !== want.zero_input)
            flag_error("result mismatch", want, got);
        end
        take_done = 1;
      end
    end
  end

  initial begin
    logic [PREC_BITS-1:0] edge_precs[12];
    logic [PREC_BITS-1:0] prec;
    logic [CFG_BITS-1:0]  mode;
    edge_precs = '{8'd1, 8'd128, 8'd0, 8'd255, 8'd2, 8'd127,
                   8'd63, 8'd65, 8'd53, 8'd24, 8'd113, 8'd129};
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings first, then each mode on the same edge values
    queue_directed();
    drain();
    set_rounding(8'd64, CFG_BITS'(MODE_TO_ZERO));
    queue_directed();
    drain();
    set_rounding(8'd64, CFG_BITS'(MODE_AWAY));
    queue_directed();
    drain();
    set_rounding(8'd1, CFG_BITS'(MODE_FLOOR));
    queue_directed();
    drain();
    set_rounding(8'd128, CFG_BITS'(MODE_CEIL));
    queue_directed();
    drain();

    for (int i = 0; i < 26; i++) begin
      if (i < 12)
        prec = edge_precs[i];
      else if ($urandom_range(0, 1))
        prec = PREC_BITS'($urandom_range(1, 128));
      else
        prec = PREC_BITS'($urandom_range(0, 255));
      mode = (i < 8) ? CFG_BITS'(i) : CFG_BITS'($urandom_range(0, 7));
      if ($urandom_range(0, 3) == 0)
        mode[CFG_BITS-1:MODE_BITS] = (CFG_BITS - MODE_BITS)'($urandom);
      set_rounding(prec, mode);
      send_idle_max = (i == 1 || $urandom_range(0, 3) == 0) ? 0 : 9;
      take_idle_max = (i == 1 || $urandom_range(0, 3) == 0) ? 0 : 9;
      if (i == 5) begin
        queue_random(37);
        drain();
        queue_random(38);
      end else begin
        queue_random(75);
      end
      drain();
    end

    if (pending_results.size() != 0) begin
      errors += pending_results.size();
      $display("%0d results never arrived", pending_results.size());
    end
    $display("rounded %0d values under %0d register settings", n_values, n_settings);
    $display("%0d inexact, %0d zero inputs, %0d two-word mantissas",
             n_inexact, n_zero, n_two_words);
    if (errors == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

  initial begin
    #5000000;
    $display("tb_top: errors");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/rwip_pkg.sv
rtl/rwip_lzc.sv
rtl/rwip_norm.sv
rtl/rwip_round.sv
rtl/rwip_incr.sv
rtl/round_wide_integer_to_precision.sv
verif/tb_top.sv
